// ----- rtl/first_fit_heap_allocator_defines.svh -----
// Assertion macros used by the port-level checker file (ffa_checker.sv).
// No dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ffa_pkg.sv -----
// Package for the first-fit heap allocator: default sizes, codes, states.
// No dependencies.
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int unsigned FFA_HEAP_BYTES   = 1024 * 100;
  localparam int unsigned FFA_HEADER_BYTES = 16;
  localparam int unsigned FFA_MAX_BLOCKS   = 64;
  localparam int unsigned FFA_FIELD_W      = 17;

  typedef enum logic [2:0] {
    STAT_ALLOC   = 3'd0,
    STAT_NOFIT   = 3'd1,
    STAT_FREED   = 3'd2,
    STAT_UNKNOWN = 3'd3,
    STAT_NULL    = 3'd4
  } ffa_status_e;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_S_SCAN,
    ST_S_WNEW,
    ST_S_RDNX,
    ST_S_WNX,
    ST_A_SPLIT,
    ST_A_GRANT,
    ST_F_RD,
    ST_F_CHK,
    ST_F_NX,
    ST_F_NXC,
    ST_F_NNR,
    ST_F_NNW,
    ST_F_PV,
    ST_F_PVC,
    ST_F_BNR,
    ST_F_BNW,
    ST_RESP
  } ffa_state_e;

endpackage

// ----- rtl/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator with coalescing; uses ffa_pkg and ffa_ram.
// Operation: allocate walks the block list from slot 0, scans for a spare record slot on a
// split and then updates the links; free searches the slots for its block and then merges it
// with free neighbours; the result word then waits in ST_RESP.
// One word at a time: ready stays low from acceptance until the result is taken.
// Reset: one cycle after reset writes the single free block into slot 0, then ready rises.
`timescale 1ns / 1ps

module first_fit_heap_allocator
  import ffa_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = FFA_HEAP_BYTES,
  parameter int unsigned HEADER_BYTES = FFA_HEADER_BYTES,
  parameter int unsigned MAX_BLOCKS   = FFA_MAX_BLOCKS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   req_type_i,
  input  logic [FFA_FIELD_W-1:0] req_size_i,
  input  logic [FFA_FIELD_W-1:0] free_offset_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             status_o,
  output logic [FFA_FIELD_W-1:0] data_offset_o
);

  localparam int unsigned AW = $clog2(HEAP_BYTES + 1);
  localparam int unsigned CW = ((AW > FFA_FIELD_W) ? AW : FFA_FIELD_W) + 2;
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned SW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned RW = 2 * AW + 1 + 2 * SW;
  localparam int unsigned PV_LO = 2 * AW + 1 + SW;

  localparam logic [SW-1:0] NIL   = SW'(MAX_BLOCKS);
  localparam logic [CW-1:0] HDR_C = CW'(HEADER_BYTES);

  function automatic logic [RW-1:0] pack_rec(input logic [AW-1:0] st,
                                             input logic [AW-1:0] ln,
                                             input logic          iu,
                                             input logic [SW-1:0] nx,
                                             input logic [SW-1:0] pv);
    return {pv, nx, iu, ln, st};
  endfunction

  ffa_state_e            state_q, state_d;
  logic [MAX_BLOCKS-1:0] valid_q, valid_d;
  logic [CW-1:0]         need_q, need_d;
  logic [FFA_FIELD_W-1:0] off_q, off_d;
  logic [SW-1:0]         cur_q, cur_d;
  logic [SW-1:0]         steps_q, steps_d;
  logic [SW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         ns_q, ns_d;
  logic [SW-1:0]         link_q, link_d;
  logic [RW-1:0]         rec_q, rec_d;
  logic [2:0]            status_q, status_d;
  logic [FFA_FIELD_W-1:0] data_q, data_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  logic [AW-1:0] rd_start, rd_len, rec_start, rec_len;
  logic          rd_inuse;
  logic [SW-1:0] rd_next, rd_prev, rec_next, rec_prev;

  assign rd_start  = ram_rdata[AW-1:0];
  assign rd_len    = ram_rdata[2*AW-1:AW];
  assign rd_inuse  = ram_rdata[2*AW];
  assign rd_next   = ram_rdata[PV_LO-1:2*AW+1];
  assign rd_prev   = ram_rdata[RW-1:PV_LO];
  assign rec_start = rec_q[AW-1:0];
  assign rec_len   = rec_q[2*AW-1:AW];
  assign rec_next  = rec_q[PV_LO-1:2*AW+1];
  assign rec_prev  = rec_q[RW-1:PV_LO];

  ffa_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_BLOCKS)
  ) u_ffa_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      valid_q <= MAX_BLOCKS'(1);
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q   <= need_d;
    off_q    <= off_d;
    cur_q    <= cur_d;
    steps_q  <= steps_d;
    idx_q    <= idx_d;
    ns_q     <= ns_d;
    link_q   <= link_d;
    rec_q    <= rec_d;
    status_q <= status_d;
    data_q   <= data_d;
  end

  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    need_d    = need_q;
    off_d     = off_q;
    cur_d     = cur_q;
    steps_d   = steps_q;
    idx_d     = idx_q;
    ns_d      = ns_q;
    link_d    = link_q;
    rec_d     = rec_q;
    status_d  = status_q;
    data_d    = data_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = pack_rec('0, AW'(HEAP_BYTES), 1'b0, NIL, NIL);
        state_d   = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!req_type_i) begin
            need_d  = CW'(req_size_i) + HDR_C;
            cur_d   = '0;
            steps_d = '0;
            state_d = ST_A_RD;
          end else if (free_offset_i == '0) begin
            status_d = STAT_NULL;
            data_d   = '0;
            state_d  = ST_RESP;
          end else begin
            off_d   = free_offset_i;
            idx_d   = '0;
            state_d = ST_F_RD;
          end
        end
      end
      ST_A_RD: begin
        if (steps_q == NIL || cur_q == NIL) begin
          status_d = STAT_NOFIT;
          data_d   = '0;
          state_d  = ST_RESP;
        end else begin
          ram_raddr = cur_q[IW-1:0];
          state_d   = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        rec_d = ram_rdata;
        if (valid_q[cur_q[IW-1:0]] && !rd_inuse && CW'(rd_len) >= need_q) begin
          if (CW'(rd_len) > need_q + HDR_C) begin
            idx_d   = '0;
            state_d = ST_S_SCAN;
          end else begin
            state_d = ST_A_GRANT;
          end
        end else begin
          cur_d   = rd_next;
          steps_d = steps_q + SW'(1);
          state_d = ST_A_RD;
        end
      end
      ST_S_SCAN: begin
        if (idx_q == NIL) begin
          state_d = ST_A_GRANT;
        end else if (!valid_q[idx_q[IW-1:0]]) begin
          ns_d    = idx_q[IW-1:0];
          state_d = ST_S_WNEW;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      ST_S_WNEW: begin
        ram_we    = 1'b1;
        ram_waddr = ns_q;
        ram_wdata = pack_rec(AW'(CW'(rec_start) + need_q), AW'(CW'(rec_len) - need_q),
                             1'b0, rec_next, cur_q);
        valid_d[ns_q] = 1'b1;
        state_d = (rec_next != NIL) ? ST_S_RDNX : ST_A_SPLIT;
      end
      ST_S_RDNX: begin
        ram_raddr = rec_next[IW-1:0];
        state_d   = ST_S_WNX;
      end
      ST_S_WNX: begin
        ram_we    = 1'b1;
        ram_waddr = rec_next[IW-1:0];
        ram_wdata = {SW'(ns_q), ram_rdata[PV_LO-1:0]};
        state_d   = ST_A_SPLIT;
      end
      ST_A_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q[IW-1:0];
        ram_wdata = pack_rec(rec_start, AW'(need_q), 1'b1, SW'(ns_q), rec_prev);
        status_d  = STAT_ALLOC;
        data_d    = FFA_FIELD_W'(CW'(rec_start) + HDR_C);
        state_d   = ST_RESP;
      end
      ST_A_GRANT: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q[IW-1:0];
        ram_wdata = pack_rec(rec_start, rec_len, 1'b1, rec_next, rec_prev);
        status_d  = STAT_ALLOC;
        data_d    = FFA_FIELD_W'(CW'(rec_start) + HDR_C);
        state_d   = ST_RESP;
      end
      ST_F_RD: begin
        if (idx_q == NIL) begin
          status_d = STAT_UNKNOWN;
          data_d   = '0;
          state_d  = ST_RESP;
        end else begin
          ram_raddr = idx_q[IW-1:0];
          state_d   = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        if (valid_q[idx_q[IW-1:0]] && (CW'(rd_start) + HDR_C == CW'(off_q))) begin
          rec_d   = ram_rdata;
          cur_d   = idx_q;
          state_d = ST_F_NX;
        end else begin
          idx_d   = idx_q + SW'(1);
          state_d = ST_F_RD;
        end
      end
      ST_F_NX: begin
        if (rec_next != NIL) begin
          ram_raddr = rec_next[IW-1:0];
          state_d   = ST_F_NXC;
        end else begin
          state_d = ST_F_PV;
        end
      end
      ST_F_NXC: begin
        if (!rd_inuse) begin
          rec_d  = pack_rec(rec_start, rec_len + rd_len, 1'b0, rd_next, rec_prev);
          valid_d[rec_next[IW-1:0]] = 1'b0;
          link_d  = rd_next;
          state_d = (rd_next != NIL) ? ST_F_NNR : ST_F_PV;
        end else begin
          state_d = ST_F_PV;
        end
      end
      ST_F_NNR: begin
        ram_raddr = link_q[IW-1:0];
        state_d   = ST_F_NNW;
      end
      ST_F_NNW: begin
        ram_we    = 1'b1;
        ram_waddr = link_q[IW-1:0];
        ram_wdata = {cur_q, ram_rdata[PV_LO-1:0]};
        state_d   = ST_F_PV;
      end
      ST_F_PV: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q[IW-1:0];
        ram_wdata = pack_rec(rec_start, rec_len, 1'b0, rec_next, rec_prev);
        if (rec_prev != NIL) begin
          ram_raddr = rec_prev[IW-1:0];
          state_d   = ST_F_PVC;
        end else begin
          status_d = STAT_FREED;
          data_d   = '0;
          state_d  = ST_RESP;
        end
      end
      ST_F_PVC: begin
        status_d = STAT_FREED;
        data_d   = '0;
        state_d  = ST_RESP;
        if (!rd_inuse) begin
          ram_we    = 1'b1;
          ram_waddr = rec_prev[IW-1:0];
          ram_wdata = pack_rec(rd_start, rd_len + rec_len, 1'b0, rec_next, rd_prev);
          valid_d[cur_q[IW-1:0]] = 1'b0;
          if (rec_next != NIL) begin
            state_d = ST_F_BNR;
          end
        end
      end
      ST_F_BNR: begin
        ram_raddr = rec_next[IW-1:0];
        state_d   = ST_F_BNW;
      end
      ST_F_BNW: begin
        ram_we    = 1'b1;
        ram_waddr = rec_next[IW-1:0];
        ram_wdata = {rec_prev, ram_rdata[PV_LO-1:0]};
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign status_o      = status_q;
  assign data_offset_o = data_q;

endmodule

// ----- rtl/ffa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ffa_checker.sv -----
// Port-level checker for the first-fit heap allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_heap_allocator_defines.svh.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_defines.svh"

module ffa_checker
  import ffa_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   req_type_i,
  input logic [FFA_FIELD_W-1:0] req_size_i,
  input logic [FFA_FIELD_W-1:0] free_offset_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [2:0]             status_o,
  input logic [FFA_FIELD_W-1:0] data_offset_o
);

  `FFA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(data_offset_o), "result word changed while stalled")
  `FFA_ASSERT_IMP(a_one_at_a_time, clk_i, rst_ni, out_valid_o, !in_ready_o, "input ready while a result is pending")
  `FFA_ASSERT_NXT(a_no_ready_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")
  `FFA_ASSERT_IMP(a_offset_zero_on_fail, clk_i, rst_ni, out_valid_o && status_o != STAT_ALLOC, data_offset_o == '0, "nonzero offset without a grant")

endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (.*);

// ----- bench/tb_first_fit_heap_allocator.sv -----
// Testbench for first_fit_heap_allocator: directed and random allocate/free words,
// checked against a scoreboard that keeps its own copy of the block table.
// Depends on ffa_pkg and the allocator RTL.
`timescale 1ns / 1ps

class ffa_scoreboard;
  localparam int NSLOT = ffa_pkg::FFA_MAX_BLOCKS;
  localparam int HDR   = ffa_pkg::FFA_HEADER_BYTES;

  bit [16:0] blk_base[NSLOT];
  bit [16:0] blk_len[NSLOT];
  bit        blk_busy[NSLOT];
  bit        blk_live[NSLOT];
  bit [6:0]  blk_next[NSLOT];
  bit [6:0]  blk_prev[NSLOT];

  ffa_pkg::ffa_status_e want_status[$];
  bit [16:0]            want_offset[$];
  int                   errors;

  function new();
    errors = 0;
    for (int i = 0; i < NSLOT; i++) clear_slot(i);
    blk_live[0] = 1'b1;
    blk_len[0]  = 17'(ffa_pkg::FFA_HEAP_BYTES);
  endfunction

  function void clear_slot(int s);
    blk_live[s] = 1'b0;
    blk_base[s] = '0;
    blk_len[s]  = '0;
    blk_busy[s] = 1'b0;
    blk_next[s] = 7'(NSLOT);
    blk_prev[s] = 7'(NSLOT);
  endfunction

  function int pending();
    return want_status.size();
  endfunction

  function void push(ffa_pkg::ffa_status_e st, bit [16:0] off);
    want_status.push_back(st);
    want_offset.push_back(off);
  endfunction

  function bit [16:0] carve(bit [16:0] size);
    int unsigned need;
    int unsigned cur;
    int unsigned spare;
    int unsigned nx;
    bit [16:0]   off;
    need = int'(size) + HDR;
    cur  = 0;
    for (int steps = 0; steps < NSLOT && cur < NSLOT; steps++) begin
      if (blk_live[cur] && !blk_busy[cur] && int'(blk_len[cur]) >= need) begin
        if (int'(blk_len[cur]) > need + HDR) begin
          spare = NSLOT;
          for (int i = NSLOT - 1; i >= 0; i--) if (!blk_live[i]) spare = i;
          if (spare < NSLOT) begin
            nx = blk_next[cur];
            blk_live[spare] = 1'b1;
            blk_base[spare] = 17'(blk_base[cur] + need);
            blk_len[spare]  = 17'(blk_len[cur] - need);
            blk_busy[spare] = 1'b0;
            blk_next[spare] = 7'(nx);
            blk_prev[spare] = 7'(cur);
            if (nx < NSLOT) blk_prev[nx] = 7'(spare);
            blk_next[cur] = 7'(spare);
            blk_len[cur]  = 17'(need);
          end
        end
        blk_busy[cur] = 1'b1;
        off = 17'(blk_base[cur] + HDR);
        push(ffa_pkg::STAT_ALLOC, off);
        return off;
      end
      cur = blk_next[cur];
    end
    push(ffa_pkg::STAT_NOFIT, '0);
    return '0;
  endfunction

  function void release_block(bit [16:0] off);
    int unsigned b;
    int unsigned nx;
    int unsigned nn;
    int unsigned pv;
    b = NSLOT;
    if (off == 0) begin
      push(ffa_pkg::STAT_NULL, '0);
      return;
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (b == NSLOT && blk_live[i] && int'(blk_base[i]) + HDR == int'(off)) b = i;
    end
    if (b == NSLOT) begin
      push(ffa_pkg::STAT_UNKNOWN, '0);
      return;
    end
    blk_busy[b] = 1'b0;
    nx = blk_next[b];
    if (nx < NSLOT && !blk_busy[nx]) begin
      nn = blk_next[nx];
      blk_len[b]  = 17'(blk_len[b] + blk_len[nx]);
      blk_next[b] = 7'(nn);
      if (nn < NSLOT) blk_prev[nn] = 7'(b);
      clear_slot(nx);
    end
    pv = blk_prev[b];
    if (pv < NSLOT && !blk_busy[pv]) begin
      nn = blk_next[b];
      blk_len[pv]  = 17'(blk_len[pv] + blk_len[b]);
      blk_next[pv] = 7'(nn);
      if (nn < NSLOT) blk_prev[nn] = 7'(pv);
      clear_slot(b);
    end
    push(ffa_pkg::STAT_FREED, '0);
  endfunction

  // returns the granted data offset, 0 when none
  function bit [16:0] note_input(bit kind, bit [16:0] size, bit [16:0] off);
    if (kind == 1'b0) return carve(size);
    release_block(off);
    return '0;
  endfunction

  function void check_result(logic [2:0] st, logic [16:0] off);
    ffa_pkg::ffa_status_e es;
    bit [16:0]            eo;
    if (want_status.size() == 0) begin
      $error("result word with no expected word: status %0d data_offset %0d", st, off);
      errors++;
      return;
    end
    es = want_status.pop_front();
    eo = want_offset.pop_front();
    if (st !== es) begin
      $error("status: expected %0d, actual %0d", es, st);
      errors++;
    end
    if (off !== eo) begin
      $error("data_offset: expected %0d, actual %0d", eo, off);
      errors++;
    end
  endfunction
endclass

module tb_first_fit_heap_allocator;
  import ffa_pkg::*;

  localparam int REQ_ALLOC = 0;
  localparam int REQ_FREE  = 1;
  localparam int STALL_LIMIT = 6000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   req_type_i = 1'b0;
  logic [FFA_FIELD_W-1:0] req_size_i = '0;
  logic [FFA_FIELD_W-1:0] free_offset_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [2:0]             status_o;
  logic [FFA_FIELD_W-1:0] data_offset_o;

  ffa_scoreboard heap_sb = new();
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_reqs = 0;
  int            hold_seen = 0;
  int            hold_left = 0;
  int            quiet_cycles = 0;
  bit [16:0]     live_offs[$];
  bit [16:0]     last_freed = 17'd16;

  first_fit_heap_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .req_size_i   (req_size_i),
    .free_offset_i(free_offset_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .data_offset_o(data_offset_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen   <= hold_reqs;
      hold_left   <= 400;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) heap_sb.check_result(status_o, data_offset_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_first_fit_heap_allocator NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(int kind, bit [16:0] size, bit [16:0] off);
    bit [16:0] got;
    in_valid_i    <= 1'b1;
    req_type_i    <= kind[0];
    req_size_i    <= size;
    free_offset_i <= off;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    got = heap_sb.note_input(kind[0], size, off);
    if (kind == REQ_ALLOC && got != 0) live_offs.push_back(got);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (heap_sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic free_live(int idx);
    bit [16:0] off;
    off = live_offs[idx];
    live_offs.delete(idx);
    last_freed = off;
    send_word(REQ_FREE, 17'($urandom), off);
  endtask

  task automatic random_word();
    int        r;
    bit [16:0] size;
    r = $urandom_range(99);
    if (live_offs.size() > 0 && r < 40) begin
      free_live($urandom_range(live_offs.size() - 1));
    end else if (r < 46) begin
      case ($urandom_range(3))
        0: send_word(REQ_FREE, 17'($urandom), '0);
        1: send_word(REQ_FREE, 17'($urandom), last_freed);
        default: send_word(REQ_FREE, 17'($urandom), 17'($urandom));
      endcase
    end else begin
      r = $urandom_range(99);
      if (r < 80) size = 17'($urandom_range(0, 1500));
      else if (r < 95) size = 17'($urandom_range(0, 40000));
      else size = 17'($urandom);
      send_word(REQ_ALLOC, size, 17'($urandom));
    end
  endtask

  initial begin
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 53, 0, 19};
    stall_set = '{0, 0, 53, 19};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(REQ_ALLOC, 17'd0, 17'h1ffff);
    send_word(REQ_FREE, 17'h1ffff, 17'd16);
    send_word(REQ_FREE, 17'd0, 17'd16);
    send_word(REQ_ALLOC, 17'd102400, '0);
    send_word(REQ_ALLOC, 17'h1ffff, '0);
    send_word(REQ_FREE, '0, '0);
    send_word(REQ_FREE, '0, 17'h1ffff);
    send_word(REQ_ALLOC, 17'd102384, '0);
    send_word(REQ_ALLOC, 17'd0, '0);
    send_word(REQ_FREE, '0, 17'd16);
    send_word(REQ_ALLOC, 17'd102368, '0);
    send_word(REQ_FREE, '0, 17'd16);
    live_offs.delete();
    send_word(REQ_ALLOC, 17'd100, '0);
    send_word(REQ_ALLOC, 17'd100, '0);
    send_word(REQ_ALLOC, 17'd100, '0);
    send_word(REQ_ALLOC, 17'd0, '0);
    free_live(1);
    free_live(0);
    free_live(1);
    free_live(0);
    send_word(REQ_FREE, '0, 17'd148);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int n = 0; n < 335; n++) begin
        if (ph == 1 && n == 100) begin
          send_idle_pct = 0;
          hold_reqs++;
        end
        if (ph == 1 && n == 110) send_idle_pct = idle_set[ph];
        random_word();
      end
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (heap_sb.errors == 0 && heap_sb.pending() == 0) begin
      $display("tb_first_fit_heap_allocator OK");
    end else begin
      $display("tb_first_fit_heap_allocator NOT OK");
    end
    $finish;
  end
endmodule
